// ----- rtl/gpe_pkg.sv -----
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared constants, register indexes and helpers for the galactic
// potential energy pipeline.
// ----------------------------------------------------------------------------
package gpe_pkg;

  // fixed point format of every intermediate
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned CFG_W      = 40;
  localparam int unsigned IW         = 60;
  localparam logic [IW-1:0] SAT_CAP  = {IW{1'b1}};

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // halo core radius squared (integer part)
  localparam int unsigned HALO_CORE_SQ = 144;

  // unit latencies
  localparam int unsigned MUL_LAT  = 3;
  localparam int unsigned SQRT_W   = (IW + FRAC_BITS + 1) / 2;
  localparam int unsigned SQRT_LAT = SQRT_W;
  localparam int unsigned LN_LAT   = FRAC_BITS + 3;

  // register indexes
  localparam logic [2:0] REG_PARTICLE_MASS   = 3'd0;
  localparam logic [2:0] REG_DISK_SCALE_A    = 3'd1;
  localparam logic [2:0] REG_DISK_SCALE_B    = 3'd2;
  localparam logic [2:0] REG_DISK_MASS       = 3'd3;
  localparam logic [2:0] REG_BULGE_SCALE     = 3'd4;
  localparam logic [2:0] REG_BULGE_MASS      = 3'd5;
  localparam logic [2:0] REG_HALO_VELOCITY   = 3'd6;
  localparam logic [2:0] REG_HALO_FLATTENING = 3'd7;

  // register reset values
  localparam logic [CFG_W-1:0] RST_PARTICLE_MASS   = 40'd29482;
  localparam logic [CFG_W-1:0] RST_DISK_SCALE_A    = 40'd425984;
  localparam logic [CFG_W-1:0] RST_DISK_SCALE_B    = 40'd17039;
  localparam logic [CFG_W-1:0] RST_DISK_MASS       = 40'd29220266836;
  localparam logic [CFG_W-1:0] RST_BULGE_SCALE     = 40'd45875;
  localparam logic [CFG_W-1:0] RST_BULGE_MASS      = 40'd10024019689;
  localparam logic [CFG_W-1:0] RST_HALO_VELOCITY   = 40'd7640619;
  localparam logic [CFG_W-1:0] RST_HALO_FLATTENING = 40'd58982;

  // saturating add of two capped values
  function automatic logic [IW-1:0] add_sat(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[IW] ? SAT_CAP : s[IW-1:0];
  endfunction

endpackage

// ----- rtl/gpe_dly.sv -----
// ----------------------------------------------------------------------------
// gpe_dly
// Enable-gated delay line that keeps side values aligned with the pipeline.
// ----------------------------------------------------------------------------
module gpe_dly #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] tap_q [DEPTH];

  // shift on every advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign d_o = tap_q[DEPTH-1];

endmodule

// ----- rtl/gpe_mulq.sv -----
// ----------------------------------------------------------------------------
// gpe_mulq
// Three-stage fixed point multiplier: 32x32 partial products, sum,
// then truncation of the fraction and saturation.
// ----------------------------------------------------------------------------
module gpe_mulq (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [63:0]             a_i,
  input  logic [63:0]             b_i,
  output logic [gpe_pkg::IW-1:0]  p_o
);

  logic [31:0]  al, ah, bl, bh;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod_q;
  logic [127:0] sh;
  logic [gpe_pkg::IW-1:0] res_q;

  assign al = a_i[31:0];
  assign ah = a_i[63:32];
  assign bl = b_i[31:0];
  assign bh = b_i[63:32];
  assign sh = prod_q >> gpe_pkg::FRAC_BITS;

  // partial products, full sum, scale and clip
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q  <= al * bl;
      p01_q  <= al * bh;
      p10_q  <= ah * bl;
      p11_q  <= ah * bh;
      prod_q <= {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
                + {p11_q, 64'd0};
      res_q  <= (|sh[127:gpe_pkg::IW]) ? gpe_pkg::SAT_CAP : sh[gpe_pkg::IW-1:0];
    end
  end

  assign p_o = res_q;

endmodule

// ----- rtl/gpe_sqrt.sv -----
// ----------------------------------------------------------------------------
// gpe_sqrt
// Pipelined digit-by-digit square root of a fixed point value, one root bit
// per stage.
// ----------------------------------------------------------------------------
module gpe_sqrt (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [gpe_pkg::IW-1:0] v_i,
  output logic [gpe_pkg::IW-1:0] root_o
);

  localparam int unsigned RW  = gpe_pkg::SQRT_W;
  localparam int unsigned RDW = 2 * RW;

  logic [RW+1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [RDW-1:0] rad_q  [RW];
  logic [RDW-1:0] rad0;

  assign rad0 = RDW'({v_i, {gpe_pkg::FRAC_BITS{1'b0}}});

  for (genvar i = 0; i < RW; i++) begin : g_st
    logic [RW+1:0]  rem_in;
    logic [RW-1:0]  root_in;
    logic [RDW-1:0] rad_in;
    logic [RW+3:0]  cur;
    logic [RW+3:0]  trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // bring down two radicand bits and try the next root bit
    assign cur   = {rem_in, rad_in[RDW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (RW+2)'(cur - trial) : cur[RW+1:0];
        root_q[i] <= {root_in[RW-2:0], ge};
        rad_q[i]  <= rad_in << 2;
      end
    end
  end

  assign root_o = gpe_pkg::IW'(root_q[RW-1]);

endmodule

// ----- rtl/gpe_div.sv -----
// ----------------------------------------------------------------------------
// gpe_div
// Pipelined restoring divider: floor(num * 2^FRAC / den), one quotient bit
// per stage, a zero divisor taken as one LSB, result clipped at the cap.
// ----------------------------------------------------------------------------
module gpe_div #(
  parameter int unsigned NUM_W = 40
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [gpe_pkg::IW-1:0] den_i,
  output logic [gpe_pkg::IW-1:0] quo_o
);

  localparam int unsigned IW = gpe_pkg::IW;
  localparam int unsigned NW = NUM_W + gpe_pkg::FRAC_BITS;

  logic [IW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [NW-1:0] dvd_q [NW];
  logic [IW-1:0] den_q [NW];
  logic [IW-1:0] res_q;
  logic [IW-1:0] den0;
  logic [IW-1:0] quo_clip;

  assign den0 = (den_i == '0) ? IW'(1) : den_i;

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [IW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [NW-1:0] dvd_in;
    logic [IW-1:0] den_in;
    logic [IW:0]   cur;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = {num_i, {gpe_pkg::FRAC_BITS{1'b0}}};
      assign den_in = den0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign dvd_in = dvd_q[i-1];
      assign den_in = den_q[i-1];
    end

    // shift in one dividend bit, subtract when it fits
    assign cur = {rem_in, dvd_in[NW-1]};
    assign ge  = (cur >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? IW'(cur - {1'b0, den_in}) : cur[IW-1:0];
        quo_q[i] <= {quo_in[NW-2:0], ge};
        dvd_q[i] <= dvd_in << 1;
        den_q[i] <= den_in;
      end
    end
  end

  // clip to the cap
  if (NW > IW) begin : g_wide
    assign quo_clip = (|quo_q[NW-1][NW-1:IW]) ? gpe_pkg::SAT_CAP : quo_q[NW-1][IW-1:0];
  end else begin : g_narrow
    assign quo_clip = IW'(quo_q[NW-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= quo_clip;
    end
  end

  assign quo_o = res_q;

endmodule

// ----- rtl/gpe_ln.sv -----
// ----------------------------------------------------------------------------
// gpe_ln
// Pipelined natural log: leading one search, normalize to Q1.30, one
// squaring per fraction bit of log2, then scale by ln(2).
// ----------------------------------------------------------------------------
module gpe_ln (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [gpe_pkg::IW-1:0] v_i,
  output logic [gpe_pkg::IW-1:0] ln_o
);

  localparam int unsigned IW = gpe_pkg::IW;
  localparam int unsigned F  = gpe_pkg::FRAC_BITS;
  localparam int unsigned KW = $clog2(IW);
  localparam int unsigned LW = KW + F;

  logic [KW-1:0] k_lz;
  logic [IW-1:0] va_q;
  logic [KW-1:0] ka_q, kb_q;
  logic          za_q, zb_q;
  logic [30:0]   mb_q;
  logic [30:0]   m_q    [F];
  logic [F-1:0]  frac_q [F];
  logic [KW-1:0] k_q    [F];
  logic          z_q    [F];
  logic [LW-1:0] lg;
  logic [LW+31:0] lg_prod;
  logic [IW-1:0] res_q;

  // leading one position
  always_comb begin
    k_lz = '0;
    for (int j = 0; j < IW; j++) begin
      if (v_i[j]) k_lz = KW'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      va_q <= v_i;
      ka_q <= k_lz;
      za_q <= (v_i == '0);
      // normalize mantissa to Q1.30
      if (ka_q >= KW'(30)) mb_q <= 31'(va_q >> (ka_q - KW'(30)));
      else                 mb_q <= 31'(va_q << (KW'(30) - ka_q));
      kb_q <= ka_q;
      zb_q <= za_q;
    end
  end

  for (genvar i = 0; i < F; i++) begin : g_sq
    logic [30:0]   m_in;
    logic [F-1:0]  frac_in;
    logic [KW-1:0] k_in;
    logic          z_in;
    logic [61:0]   sq;
    logic          hi;

    if (i == 0) begin : g_first
      assign m_in    = mb_q;
      assign frac_in = '0;
      assign k_in    = kb_q;
      assign z_in    = zb_q;
    end else begin : g_next
      assign m_in    = m_q[i-1];
      assign frac_in = frac_q[i-1];
      assign k_in    = k_q[i-1];
      assign z_in    = z_q[i-1];
    end

    // square; a result at or above two yields a one bit
    assign sq = m_in * m_in;
    assign hi = sq[61];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i]    <= hi ? sq[61:31] : sq[60:30];
        frac_q[i] <= {frac_in[F-2:0], hi};
        k_q[i]    <= k_in;
        z_q[i]    <= z_in;
      end
    end
  end

  // log2 to ln, clamped at zero below one
  assign lg      = {KW'(k_q[F-1] - KW'(F)), frac_q[F-1]};
  assign lg_prod = lg * gpe_pkg::LN2_Q32;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_q[F-1] || (k_q[F-1] < KW'(F))) res_q <= '0;
      else                                 res_q <= IW'(lg_prod[LW+31:32]);
    end
  end

  assign ln_o = res_q;

endmodule

// ----- rtl/galactic_potential_energy.sv -----
// ----------------------------------------------------------------------------
// galactic_potential_energy
// Total energy of one particle in a disk + bulge + log halo potential.
// ----------------------------------------------------------------------------
// Fully pipelined: one particle is accepted every cycle unless the output
// stalls. The latency is set by the disk path: two square root units (one
// root bit per stage) in series with a restoring divider that resolves one
// quotient bit per stage. A stall on the output freezes the whole pipeline;
// the output register lets a new beat in whenever the result beat is taken.
// Registers are written through the cfg channel, which is always ready, and
// must only change while no particle is in flight.
module galactic_potential_energy #(
  parameter int unsigned DATA_WIDTH = gpe_pkg::DATA_WIDTH,
  localparam int unsigned IN_TW = ((6 * DATA_WIDTH + 48 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, snapshot_time, body_index
  input  logic [IN_TW-1:0]       s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // time_tag, particle_number, total_energy
  output logic [95:0]            m_axis_tdata,
  // saturated
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [gpe_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IW  = gpe_pkg::IW;
  localparam int unsigned CW  = gpe_pkg::CFG_W;
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned LM  = gpe_pkg::MUL_LAT;
  localparam int unsigned LS  = gpe_pkg::SQRT_LAT;
  localparam int unsigned LDC = CW + gpe_pkg::FRAC_BITS + 1;
  localparam int unsigned LDZ = DW + gpe_pkg::FRAC_BITS + 1;
  localparam int unsigned LL  = gpe_pkg::LN_LAT;

  // schedule, in stages after the input register
  localparam int unsigned T_R2    = LM + 1;
  localparam int unsigned T_QP    = T_R2 + LS;
  localparam int unsigned T_AP    = T_QP + 1;
  localparam int unsigned T_APAP  = T_AP + LM;
  localparam int unsigned T_SP    = T_APAP + 1;
  localparam int unsigned T_SQ2   = T_SP + LS;
  localparam int unsigned T_DISK  = T_SQ2 + LDC;
  localparam int unsigned T_RB    = T_R2 + LS + 1;
  localparam int unsigned T_BULGE = T_RB + LDC;
  localparam int unsigned T_ZZQ   = LDZ + LM;
  localparam int unsigned T_LP    = T_ZZQ + 1;
  localparam int unsigned T_HALO  = T_LP + LL + LM;
  localparam int unsigned T_KE    = T_R2 + LM;
  localparam int unsigned T_POT   = T_DISK + 1;
  localparam int unsigned T_PM    = T_POT + LM;
  localparam int unsigned T_OUT   = T_PM + 1;

  localparam logic signed [62:0] OUT_MAX = 63'sd140737488355327;
  localparam logic signed [62:0] OUT_MIN = -63'sd140737488355328;
  localparam logic [IW-1:0] D2 = IW'(gpe_pkg::HALO_CORE_SQ) << gpe_pkg::FRAC_BITS;

  logic en;

  // configuration registers
  logic [CW-1:0] mass_q, a_q, b_q, md_q, rc_q, mb_q, hv_q, q_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= gpe_pkg::RST_PARTICLE_MASS;
      a_q    <= gpe_pkg::RST_DISK_SCALE_A;
      b_q    <= gpe_pkg::RST_DISK_SCALE_B;
      md_q   <= gpe_pkg::RST_DISK_MASS;
      rc_q   <= gpe_pkg::RST_BULGE_SCALE;
      mb_q   <= gpe_pkg::RST_BULGE_MASS;
      hv_q   <= gpe_pkg::RST_HALO_VELOCITY;
      q_q    <= gpe_pkg::RST_HALO_FLATTENING;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gpe_pkg::REG_PARTICLE_MASS:   mass_q <= cfg_data_i;
        gpe_pkg::REG_DISK_SCALE_A:    a_q    <= cfg_data_i;
        gpe_pkg::REG_DISK_SCALE_B:    b_q    <= cfg_data_i;
        gpe_pkg::REG_DISK_MASS:       md_q   <= cfg_data_i;
        gpe_pkg::REG_BULGE_SCALE:     rc_q   <= cfg_data_i;
        gpe_pkg::REG_BULGE_MASS:      mb_q   <= cfg_data_i;
        gpe_pkg::REG_HALO_VELOCITY:   hv_q   <= cfg_data_i;
        gpe_pkg::REG_HALO_FLATTENING: q_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  logic [T_OUT:0] vld_q;

  assign en            = !vld_q[T_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[T_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[T_OUT-1:0], s_axis_tvalid};
    end
  end

  // input register: magnitudes of position and velocity
  logic [DW-1:0] mag      [6];
  logic [DW-1:0] mag_q    [6];
  logic [31:0]   time_q;
  logic [15:0]   idx_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag[i] = s_axis_tdata[i*DW +: DW];
      if (mag[i][DW-1]) mag[i] = ~mag[i] + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag;
      time_q <= s_axis_tdata[6*DW +: 32];
      idx_q  <= s_axis_tdata[6*DW+32 +: 16];
    end
  end

  // squares of the components
  logic [IW-1:0] sq [6];
  for (genvar i = 0; i < 6; i++) begin : g_sq
    gpe_mulq u_sq (
      .clk_i (clk_i), .en_i (en),
      .a_i (64'(mag_q[i])), .b_i (64'(mag_q[i])), .p_o (sq[i])
    );
  end

  logic [IW-1:0] bb, hv2;
  gpe_mulq u_bb (
    .clk_i (clk_i), .en_i (en), .a_i (64'(b_q)), .b_i (64'(b_q)), .p_o (bb)
  );
  gpe_mulq u_hv2 (
    .clk_i (clk_i), .en_i (en), .a_i (64'(hv_q)), .b_i (64'(hv_q)), .p_o (hv2)
  );

  // radius and speed sums
  logic [IW-1:0] r2_q, s1_q, rsum_q, v2_q;
  logic [IW-1:0] r2;
  assign r2 = gpe_pkg::add_sat(sq[0], sq[1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q   <= r2;
      s1_q   <= gpe_pkg::add_sat(sq[2], bb);
      rsum_q <= gpe_pkg::add_sat(r2, sq[2]);
      v2_q   <= gpe_pkg::add_sat(gpe_pkg::add_sat(sq[3], sq[4]), sq[5]);
    end
  end

  // kinetic energy
  logic [IW-1:0] mv2, ke_d;
  gpe_mulq u_mv2 (
    .clk_i (clk_i), .en_i (en), .a_i (64'(mass_q)), .b_i (64'(v2_q)), .p_o (mv2)
  );
  gpe_dly #(.W(IW), .DEPTH(T_PM - T_KE)) u_ke_dly (
    .clk_i (clk_i), .en_i (en), .d_i ({1'b0, mv2[IW-1:1]}), .d_o (ke_d)
  );

  // disk term
  logic [IW-1:0] qp, apap, r2_d1, sq2, disk;
  logic [IW-1:0] ap_q, sp_q;

  gpe_sqrt u_sqrt_qp (.clk_i (clk_i), .en_i (en), .v_i (s1_q), .root_o (qp));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap_q <= gpe_pkg::add_sat(IW'(a_q), qp);
      sp_q <= gpe_pkg::add_sat(r2_d1, apap);
    end
  end

  gpe_mulq u_apap (
    .clk_i (clk_i), .en_i (en), .a_i (64'(ap_q)), .b_i (64'(ap_q)), .p_o (apap)
  );
  gpe_dly #(.W(IW), .DEPTH(T_APAP - T_R2)) u_r2_dly1 (
    .clk_i (clk_i), .en_i (en), .d_i (r2_q), .d_o (r2_d1)
  );
  gpe_sqrt u_sqrt_sp (.clk_i (clk_i), .en_i (en), .v_i (sp_q), .root_o (sq2));
  gpe_div #(.NUM_W(CW)) u_div_disk (
    .clk_i (clk_i), .en_i (en), .num_i (md_q), .den_i (sq2), .quo_o (disk)
  );

  // bulge term
  logic [IW-1:0] rr, bulge, bulge_d;
  logic [IW-1:0] rb_q;

  gpe_sqrt u_sqrt_rr (.clk_i (clk_i), .en_i (en), .v_i (rsum_q), .root_o (rr));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rb_q <= gpe_pkg::add_sat(rr, IW'(rc_q));
    end
  end

  gpe_div #(.NUM_W(CW)) u_div_bulge (
    .clk_i (clk_i), .en_i (en), .num_i (mb_q), .den_i (rb_q), .quo_o (bulge)
  );
  gpe_dly #(.W(IW), .DEPTH(T_DISK - T_BULGE)) u_bulge_dly (
    .clk_i (clk_i), .en_i (en), .d_i (bulge), .d_o (bulge_d)
  );

  // halo term
  logic [IW-1:0] zq, zqzq, r2_d2, lnv, halo, halo_d;
  logic [IW-1:0] lp_q;

  gpe_div #(.NUM_W(DW)) u_div_zq (
    .clk_i (clk_i), .en_i (en), .num_i (mag_q[2]), .den_i (IW'(q_q)), .quo_o (zq)
  );
  gpe_mulq u_zqzq (
    .clk_i (clk_i), .en_i (en), .a_i (64'(zq)), .b_i (64'(zq)), .p_o (zqzq)
  );
  gpe_dly #(.W(IW), .DEPTH(T_ZZQ - T_R2)) u_r2_dly2 (
    .clk_i (clk_i), .en_i (en), .d_i (r2_q), .d_o (r2_d2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      lp_q <= gpe_pkg::add_sat(gpe_pkg::add_sat(r2_d2, zqzq), D2);
    end
  end

  gpe_ln u_ln (.clk_i (clk_i), .en_i (en), .v_i (lp_q), .ln_o (lnv));
  gpe_mulq u_halo (
    .clk_i (clk_i), .en_i (en), .a_i (64'(hv2)), .b_i (64'(lnv)), .p_o (halo)
  );
  gpe_dly #(.W(IW), .DEPTH(T_DISK - T_HALO)) u_halo_dly (
    .clk_i (clk_i), .en_i (en), .d_i (halo), .d_o (halo_d)
  );

  // potential sum and scaling by the particle mass
  logic signed [IW+1:0] pot_q;
  logic [IW+1:0]        pot_abs;
  logic [IW-1:0]        pmag;
  logic                 neg_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pot_q <= signed'({2'b00, halo_d}) - signed'({2'b00, disk})
               - signed'({2'b00, bulge_d});
    end
  end

  assign pot_abs = pot_q[IW+1] ? (IW+2)'(-pot_q) : pot_q;

  gpe_mulq u_pmag (
    .clk_i (clk_i), .en_i (en), .a_i (64'(pot_abs)), .b_i (64'(mass_q)), .p_o (pmag)
  );
  gpe_dly #(.W(1), .DEPTH(LM)) u_sign_dly (
    .clk_i (clk_i), .en_i (en), .d_i (pot_q[IW+1]), .d_o (neg_d)
  );

  // total and output clip
  logic signed [62:0] tot;
  logic [47:0]        energy_q;
  logic               sat_q;
  logic [31:0]        time_d;
  logic [15:0]        idx_d;

  assign tot = signed'({3'b000, ke_d})
               + (neg_d ? -signed'({3'b000, pmag}) : signed'({3'b000, pmag}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tot > OUT_MAX) begin
        energy_q <= OUT_MAX[47:0];
        sat_q    <= 1'b1;
      end else if (tot < OUT_MIN) begin
        energy_q <= OUT_MIN[47:0];
        sat_q    <= 1'b1;
      end else begin
        energy_q <= tot[47:0];
        sat_q    <= 1'b0;
      end
    end
  end

  gpe_dly #(.W(48), .DEPTH(T_OUT)) u_tag_dly (
    .clk_i (clk_i), .en_i (en), .d_i ({idx_q, time_q}), .d_o ({idx_d, time_d})
  );

  assign m_axis_tdata = {energy_q, idx_d, time_d};
  assign m_axis_tuser = sat_q;

endmodule

// ----- rtl/gpe_chk.sv -----
// ----------------------------------------------------------------------------
// gpe_chk
// Port-level checks for the galactic potential energy pipeline.
// ----------------------------------------------------------------------------
module gpe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // a result beat stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // an empty output never blocks the input
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // a stalled output holds the input back
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // a clipped energy sits at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[95:48] == 48'h7FFF_FFFF_FFFF) ||
      (m_axis_tdata[95:48] == 48'h8000_0000_0000))
    else $error("saturated flag without clipped energy");

endmodule

bind galactic_potential_energy gpe_chk u_gpe_chk (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for galactic_potential_energy: a directed table of
// particles and then random streams, each scored against a bit-exact energy
// model of the disk, bulge, halo and kinetic terms or its row's answer. Both
// stream sides idle at random and the register set is swapped between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IN_TW   = 240;
  localparam int unsigned PIPE_LAT = 160;
  localparam logic [59:0] CAP      = {60{1'b1}};

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] num;
    logic [47:0] energy;
    logic        sat;
  } energy_t;

  typedef struct {
    logic [31:0] px, py, pz, vx, vy, vz;
    logic [31:0] snap;
    logic [15:0] idx;
    logic        known;
    logic [47:0] e_exp;
    logic        s_exp;
  } particle_t;

  logic clk_i, rst_ni;
  logic [IN_TW-1:0] s_axis_tdata;
  logic s_axis_tvalid, s_axis_tready;
  logic [95:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tvalid, m_axis_tready;
  logic cfg_valid_i, cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [gpe_pkg::CFG_W-1:0] cfg_data_i;

  galactic_potential_energy dut (.*);

  // model copy of the register file
  logic [39:0] m_mass, m_a, m_b, m_md, m_rc, m_mb, m_hv, m_q;

  energy_t energy_q[$];
  int n_err, n_seen, n_sent, n_sat;
  bit quiet_tx, quiet_rx, long_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

  // fixed point helpers
  function automatic logic [59:0] fmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = (a * b) >> 16;
    return (p > CAP) ? CAP : p[59:0];
  endfunction

  function automatic logic [59:0] fadd(logic [59:0] a, logic [59:0] b);
    logic [60:0] s;
    s = a + b;
    return s[60] ? CAP : s[59:0];
  endfunction

  function automatic logic [59:0] fsqrt(logic [59:0] v);
    logic [127:0] n, c;
    logic [63:0] root;
    n = {68'd0, v} << 16;
    root = 0;
    for (int i = 47; i >= 0; i--) begin
      c = root | (64'd1 << i);
      if (c * c <= n) root = c;
    end
    return root[59:0];
  endfunction

  function automatic logic [59:0] fdiv(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0) den = 1;
    q = ({64'd0, num} << 16) / den;
    return (q > CAP) ? CAP : q[59:0];
  endfunction

  function automatic logic [59:0] fln(logic [59:0] v);
    logic [63:0] m, frac;
    longint k, lg;
    logic [127:0] p;
    if (v == 0) return 0;
    k = 59;
    while (!v[k]) k--;
    m = (k >= 30) ? (v >> (k - 30)) : (v << (30 - k));
    frac = 0;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    lg = (k - 16) * 65536 + longint'(frac);
    if (lg < 0) return 0;
    p = (128'(lg) * gpe_pkg::LN2_Q32) >> 32;
    return p[59:0];
  endfunction

  function automatic logic [63:0] absval(logic [31:0] r);
    return r[31] ? 64'(-r) & 64'hFFFF_FFFF : 64'(r);
  endfunction

  // expected energy of one particle under the current registers
  function automatic energy_t particle_energy(particle_t p);
    logic [59:0] r2, zz, qp, ap, sp, disk, rr, bulge, zq, lp, halo, v2, pmag;
    longint pot, pe, ke, tot;
    energy_t e;
    r2 = fadd(fmul(absval(p.px), absval(p.px)), fmul(absval(p.py), absval(p.py)));
    zz = fmul(absval(p.pz), absval(p.pz));
    qp = fsqrt(fadd(zz, fmul(64'(m_b), 64'(m_b))));
    ap = fadd(60'(m_a), qp);
    sp = fadd(r2, fmul(64'(ap), 64'(ap)));
    disk = fdiv(64'(m_md), 64'(fsqrt(sp)));
    rr = fsqrt(fadd(r2, zz));
    bulge = fdiv(64'(m_mb), 64'(fadd(rr, 60'(m_rc))));
    zq = fdiv(absval(p.pz), 64'(m_q));
    lp = fadd(fadd(r2, fmul(64'(zq), 64'(zq))), 60'(144) << 16);
    halo = fmul(64'(fmul(64'(m_hv), 64'(m_hv))), 64'(fln(lp)));
    pot = longint'(halo) - longint'(disk) - longint'(bulge);
    pmag = fmul(64'(pot < 0 ? -pot : pot), 64'(m_mass));
    pe = pot < 0 ? -longint'(pmag) : longint'(pmag);
    v2 = fadd(fadd(fmul(absval(p.vx), absval(p.vx)), fmul(absval(p.vy), absval(p.vy))),
              fmul(absval(p.vz), absval(p.vz)));
    ke = longint'(fmul(64'(m_mass), 64'(v2)) >> 1);
    tot = ke + pe;
    e.sat = 1'b0;
    if (tot > 64'sh7FFF_FFFF_FFFF) begin
      tot = 64'sh7FFF_FFFF_FFFF;
      e.sat = 1'b1;
    end
    if (tot < -64'sh8000_0000_0000) begin
      tot = -64'sh8000_0000_0000;
      e.sat = 1'b1;
    end
    e.tag = p.snap;
    e.num = p.idx;
    e.energy = tot[47:0];
    return e;
  endfunction

  // one register beat; the caller drops valid after the last one
  task automatic write_reg(logic [2:0] idx, logic [39:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      gpe_pkg::REG_PARTICLE_MASS:   m_mass = val;
      gpe_pkg::REG_DISK_SCALE_A:    m_a = val;
      gpe_pkg::REG_DISK_SCALE_B:    m_b = val;
      gpe_pkg::REG_DISK_MASS:       m_md = val;
      gpe_pkg::REG_BULGE_SCALE:     m_rc = val;
      gpe_pkg::REG_BULGE_MASS:      m_mb = val;
      gpe_pkg::REG_HALO_VELOCITY:   m_hv = val;
      gpe_pkg::REG_HALO_FLATTENING: m_q = val;
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    int w;
    w = 0;
    while (energy_q.size() != 0) @(posedge clk_i);
    while (w < PIPE_LAT) begin
      @(posedge clk_i);
      w++;
    end
  endtask

  // send one beat, with an optional random gap in front
  task automatic send_particle(particle_t p);
    energy_t e;
    int gap;
    if (!quiet_tx && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    e = particle_energy(p);
    if (p.known) begin
      e.energy = p.e_exp;
      e.sat = p.s_exp;
    end
    s_axis_tdata  <= {p.idx, p.snap, p.vz, p.vy, p.vx, p.pz, p.py, p.px};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    energy_q.push_back(e);
    n_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($urandom_range(0, 1 << 16)) * ($urandom_range(0, 1) ? 1 : -1);
      default: return 32'(int'($urandom_range(0, 30 << 16)) - (15 << 16));
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.px = rand_coord(); p.py = rand_coord(); p.pz = rand_coord();
    p.vx = rand_coord(); p.vy = rand_coord(); p.vz = rand_coord();
    p.snap = $urandom();
    p.idx = 16'($urandom());
    p.known = 1'b0;
    p.e_exp = '0;
    p.s_exp = 1'b0;
    return p;
  endfunction

  // output side: ready with random hold-offs, and one long hold
  initial begin
    int hold;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet_rx && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    energy_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[95:48], m_axis_tuser};
      n_seen++;
      if (got.sat) n_sat++;
      if (energy_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = energy_q.pop_front();
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("beat %0d: exp tag %h num %h e %h sat %b, got tag %h num %h e %h sat %b",
                     n_seen, want.tag, want.num, want.energy, want.sat,
                     got.tag, got.num, got.energy, got.sat);
        end
      end
    end
  end

  // directed table: rows with a known answer carry it
  particle_t directed[$];

  task automatic add_row(logic [31:0] c, logic [31:0] v, logic known, logic [47:0] e,
                         logic s);
    particle_t p;
    p = '{c, c, c, v, v, v, 32'hFFFF_FFFF, 16'hFFFF, known, e, s};
    directed.push_back(p);
  endtask

  typedef logic [39:0] regset_t [8];

  task automatic load_regs(regset_t r);
    for (int i = 0; i < 8; i++) write_reg(3'(i), r[i]);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    regset_t rs;
    particle_t p;
    n_err = 0; n_seen = 0; n_sent = 0; n_sat = 0;
    quiet_tx = 0; quiet_rx = 0; long_hold = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gpe_pkg::REG_PARTICLE_MASS;
    cfg_data_i = '0;
    m_mass = gpe_pkg::RST_PARTICLE_MASS;
    m_a    = gpe_pkg::RST_DISK_SCALE_A;
    m_b    = gpe_pkg::RST_DISK_SCALE_B;
    m_md   = gpe_pkg::RST_DISK_MASS;
    m_rc   = gpe_pkg::RST_BULGE_SCALE;
    m_mb   = gpe_pkg::RST_BULGE_MASS;
    m_hv   = gpe_pkg::RST_HALO_VELOCITY;
    m_q    = gpe_pkg::RST_HALO_FLATTENING;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset registers
    add_row(32'h0, 32'h0, 1'b0, '0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(32'h8000_0000, 32'h8000_0000, 1'b0, '0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'h0001_0000, 1'b0, '0, 1'b0);
    add_row(32'h0001_0000, 32'hFFFF_0000, 1'b0, '0, 1'b0);
    add_row(32'h000A_0000, 32'h00C8_0000, 1'b0, '0, 1'b0);
    foreach (directed[i]) send_particle(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    // zero mass: energy is zero whatever the particle
    write_reg(gpe_pkg::REG_PARTICLE_MASS, '0);
    cfg_valid_i <= 1'b0;
    directed.delete();
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0, 1'b0);
    add_row(32'h1234_5678, 32'h0BAD_F00D, 1'b1, '0, 1'b0);
    foreach (directed[i]) send_particle(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    // full-scale registers: huge kinetic energy clips high
    rs = '{default: 40'hFF_FFFF_FFFF};
    load_regs(rs);
    directed.delete();
    add_row(32'h0, 32'h7FFF_FFFF, 1'b1, 48'h7FFF_FFFF_FFFF, 1'b1);
    add_row(32'h8000_0000, 32'h8000_0000, 1'b0, '0, 1'b0);
    foreach (directed[i]) send_particle(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    // zero scales, zero halo, lsb flattening: zero divisors, clips low
    rs = '{40'hFF_FFFF_FFFF, 0, 0, 40'hFF_FFFF_FFFF, 0, 40'hFF_FFFF_FFFF, 0, 1};
    load_regs(rs);
    directed.delete();
    add_row(32'h0, 32'h0, 1'b1, 48'h8000_0000_0000, 1'b1);
    add_row(32'h0000_0001, 32'h0, 1'b0, '0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h0, 1'b0, '0, 1'b0);
    foreach (directed[i]) send_particle(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    // random phases: reset registers first, then random register sets
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        rs = '{gpe_pkg::RST_PARTICLE_MASS, gpe_pkg::RST_DISK_SCALE_A,
               gpe_pkg::RST_DISK_SCALE_B, gpe_pkg::RST_DISK_MASS,
               gpe_pkg::RST_BULGE_SCALE, gpe_pkg::RST_BULGE_MASS,
               gpe_pkg::RST_HALO_VELOCITY, gpe_pkg::RST_HALO_FLATTENING};
      else
        for (int i = 0; i < 8; i++)
          rs[i] = ($urandom_range(0, 3) == 0) ? {$urandom(), 8'($urandom())}
                                              : 40'($urandom_range(1, 1 << 24));
      if (rs[7] == 0) rs[7] = 1;
      load_regs(rs);
      if (ph == 1) long_hold = 1'b1;
      if (ph == 5) begin
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
      end
      for (int n = 0; n < 240; n++) begin
        p = rand_particle();
        send_particle(p);
        // one full pause on the input until the pipe is empty
        if (ph == 2 && n == 100) begin
          s_axis_tvalid <= 1'b0;
          while (energy_q.size() != 0) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b0;
      drain_pipe();
    end

    $display("sent %0d particles over 10 register sets, %0d results (%0d clipped)",
             n_sent, n_seen, n_sat);
    if (n_err == 0 && energy_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d left pending", n_err, energy_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
